// ===== design/hrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhs_pkg
// Shared types, constants and match functions of the response header scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhs_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int COUNT_EXT_W         = 64;
    localparam int POS_W               = 4;
    localparam int VALUE_W             = 31;
    localparam int PAT_MAX_LEN         = 16;
    localparam int PAT_W               = 8 * PAT_MAX_LEN;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // patterns in lower case, right-justified, first char at the highest byte
    localparam int                 PAT_CONTINUE_LEN = 12;
    localparam logic [PAT_W-1:0]   PAT_CONTINUE     = PAT_W'("100 continue");
    localparam int                 PAT_NOTFOUND_LEN = 9;
    localparam logic [PAT_W-1:0]   PAT_NOTFOUND     = PAT_W'("/1.1 404 ");
    localparam int                 PAT_LENGTH_LEN   = 15;
    localparam logic [PAT_W-1:0]   PAT_LENGTH       = PAT_W'("content-length:");

    typedef enum logic [2:0] {
        PARSE_IDLE   = 3'd0,
        PARSE_SKIP   = 3'd1,
        PARSE_BLANK  = 3'd2,
        PARSE_DIGITS = 3'd3,
        PARSE_IGNORE = 3'd4
    } parse_state_t;

    typedef enum logic [1:0] {
        BLANK_NONE    = 2'd0,
        BLANK_CR      = 2'd1,
        BLANK_CRLF    = 2'd2,
        BLANK_CRLFCR  = 2'd3
    } blank_pos_t;

    typedef struct packed {
        logic [POS_W-1:0] cont_pos;
        logic [POS_W-1:0] nf_pos;
        logic [POS_W-1:0] len_pos;
    } match_pos_t;

    typedef struct packed {
        logic [POS_W-1:0] cont_pos;
        logic [POS_W-1:0] nf_pos;
        logic [POS_W-1:0] len_pos;
        logic             cont_hit;
        logic             nf_hit;
        logic             len_hit;
    } match_t;

    typedef struct packed {
        logic               body_valid;
        logic [7:0]         body_byte;
        logic               header_done;
        logic               not_found_seen;
        logic               continue_seen;
        logic [VALUE_W-1:0] content_length;
        logic [31:0]        body_count;
        logic               length_ok;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_DELTA : c;
    endfunction

    function automatic logic [7:0] pat_char(input logic [PAT_W-1:0] pat, input int len,
                                            input int idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (idx >= 0 && idx < len)
        begin
            ch = pat[8*(len-1-idx) +: 8];
        end
        return ch;
    endfunction

    // next match length after byte c with pos bytes matched, with fallback
    function automatic logic [POS_W-1:0] match_advance(input logic [PAT_W-1:0] pat,
                                                       input int len,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [7:0] c);
        int         p;
        logic [POS_W-1:0] res;
        logic       found;
        logic       ok;
        p     = (int'(pos) >= len) ? 0 : int'(pos);
        res   = '0;
        found = 1'b0;
        if (pat_char(pat, len, p) == c)
        begin
            res   = POS_W'(p + 1);
            found = 1'b1;
        end
        for (int k = PAT_MAX_LEN - 1; k >= 1; k--)
        begin
            if (!found && k <= p)
            begin
                ok = (pat_char(pat, len, k - 1) == c);
                for (int j = 0; j < PAT_MAX_LEN - 2; j++)
                begin
                    if (j + 1 < k)
                    begin
                        if (pat_char(pat, len, j) != pat_char(pat, len, p - k + 1 + j))
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok)
                begin
                    res   = POS_W'(k);
                    found = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/http_response_header_scanner_core.sv =====
// ----------------------------------------------------------------------------
// http_response_header_scanner_core
// HTTP response header scanner: byte stream in, body bytes and header status out.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall carry one response byte per request with
//   last_of_buffer marking the end of a receive buffer and new_transfer
//   clearing all scan state ahead of that byte
//   output channel: out_valid/out_stall carry one result per input request,
//   in order: body pass-through, header_done, 404 and 100-continue flags,
//   parsed content_length, body_count and length_ok
//   path: a request lands in the input register, is scanned from there and its
//   result is registered in the result register, from which it is taken
//   throughput: one byte per cycle while no held result stalls it; the scan is
//   a single pass of matcher and parser logic between the input and result registers
//   stall: while out_stall holds a full result register, the input register
//   keeps its byte and in_stall rises only when that register is occupied;
//   a held result never changes
//   reset: rst_n clears both valid flags and all scan state (header phase,
//   zero length and count)
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_scanner_core
#(
    parameter int COUNT_WIDTH = hrhs_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          last_of_buffer,
    input  wire logic                          new_transfer,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               body_valid,
    output logic [7:0]                         body_byte,
    output logic                               header_done,
    output logic                               not_found_seen,
    output logic                               continue_seen,
    output logic [hrhs_pkg::VALUE_W-1:0]       content_length,
    output logic [31:0]                        body_count,
    output logic                               length_ok
);

    // input register
    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              fresh_reg;

    // result register
    logic              out_valid_reg;
    hrhs_pkg::result_t res_reg;
    hrhs_pkg::result_t result;

    logic              step;
    logic              in_take;

    // the held byte moves on whenever the result register is free or drains
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= data_byte;
            last_reg  <= last_of_buffer;
            fresh_reg <= new_transfer;
        end
    end

    hrhs_scan
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_scan
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (byte_reg),
        .last_of_buffer (last_reg),
        .new_transfer   (fresh_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign body_valid     = res_reg.body_valid;
    assign body_byte      = res_reg.body_byte;
    assign header_done    = res_reg.header_done;
    assign not_found_seen = res_reg.not_found_seen;
    assign continue_seen  = res_reg.continue_seen;
    assign content_length = res_reg.content_length;
    assign body_count     = res_reg.body_count;
    assign length_ok      = res_reg.length_ok;

    // input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // the blank line byte is a header byte, never body
    a_done_not_body: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_done) |-> !body_valid)
        else $error("header_done on a body byte");

    // a byte that stops the scan cannot also end the header
    a_continue_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(continue_seen && header_done))
        else $error("continue match and header end on one byte");

    // length_ok requires a positive length
    a_len_ok_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && length_ok) |-> (content_length != '0))
        else $error("length_ok with zero content_length");

endmodule

`default_nettype wire

// ===== design/hrhs_matchers.sv =====
// ----------------------------------------------------------------------------
// hrhs_matchers
// Three case-folded pattern matchers stepping together on one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_matchers
(
    input  wire logic [7:0]          c,
    input  wire hrhs_pkg::match_pos_t cur,
    output hrhs_pkg::match_t          match
);

    always_comb
    begin
        match.cont_pos = hrhs_pkg::match_advance(hrhs_pkg::PAT_CONTINUE,
                                                 hrhs_pkg::PAT_CONTINUE_LEN, cur.cont_pos, c);
        match.nf_pos   = hrhs_pkg::match_advance(hrhs_pkg::PAT_NOTFOUND,
                                                 hrhs_pkg::PAT_NOTFOUND_LEN, cur.nf_pos, c);
        match.len_pos  = hrhs_pkg::match_advance(hrhs_pkg::PAT_LENGTH,
                                                 hrhs_pkg::PAT_LENGTH_LEN, cur.len_pos, c);
        // full match detected on its last byte
        match.cont_hit = (match.cont_pos == hrhs_pkg::POS_W'(hrhs_pkg::PAT_CONTINUE_LEN));
        match.nf_hit   = (match.nf_pos == hrhs_pkg::POS_W'(hrhs_pkg::PAT_NOTFOUND_LEN));
        match.len_hit  = (match.len_pos == hrhs_pkg::POS_W'(hrhs_pkg::PAT_LENGTH_LEN));
    end

endmodule

`default_nettype wire

// ===== design/hrhs_scan.sv =====
// ----------------------------------------------------------------------------
// hrhs_scan
// Scan state, value parser, body counter and result forming for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_scan
#(
    parameter int COUNT_WIDTH = hrhs_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_of_buffer,
    input  wire logic              new_transfer,
    output hrhs_pkg::result_t      result
);

    logic                              body_phase_reg, body_phase_next;
    logic                              stopped_reg, stopped_next;
    hrhs_pkg::match_pos_t              pos_reg, pos_next, pos_cur;
    hrhs_pkg::blank_pos_t              blank_reg, blank_next, blank_cur;
    hrhs_pkg::parse_state_t            parse_reg, parse_next, parse_cur;
    logic [hrhs_pkg::VALUE_W-1:0]      accum_reg, accum_next, accum_cur;
    logic [hrhs_pkg::VALUE_W-1:0]      length_reg, length_next, length_cur;
    logic [COUNT_WIDTH-1:0]            count_reg, count_next, count_cur;
    logic                              saw_nf_reg, saw_nf_next, saw_nf_cur;
    logic                              body_cur, stopped_cur;
    logic [7:0]                        c;
    hrhs_pkg::match_t                  match;
    logic                              is_digit;
    logic [3:0]                        digit;
    logic [hrhs_pkg::VALUE_W+3:0]      accum_x10;
    logic                              prev_cr;
    logic [hrhs_pkg::COUNT_EXT_W-1:0]  count_ext;
    logic                              body_valid, header_done, continue_seen;

    assign c = hrhs_pkg::to_lower(data_byte);

    // a new transfer wipes all state before the byte is looked at
    always_comb
    begin
        body_cur    = new_transfer ? 1'b0 : body_phase_reg;
        stopped_cur = new_transfer ? 1'b0 : stopped_reg;
        pos_cur     = new_transfer ? '0 : pos_reg;
        blank_cur   = new_transfer ? hrhs_pkg::BLANK_NONE : blank_reg;
        parse_cur   = new_transfer ? hrhs_pkg::PARSE_IDLE : parse_reg;
        accum_cur   = new_transfer ? '0 : accum_reg;
        length_cur  = new_transfer ? '0 : length_reg;
        count_cur   = new_transfer ? '0 : count_reg;
        saw_nf_cur  = new_transfer ? 1'b0 : saw_nf_reg;
    end

    hrhs_matchers u_matchers
    (
        .c     (c),
        .cur   (pos_cur),
        .match (match)
    );

    assign is_digit  = (c >= hrhs_pkg::CHAR_ZERO) && (c <= hrhs_pkg::CHAR_NINE);
    assign digit     = 4'(c - hrhs_pkg::CHAR_ZERO);
    assign accum_x10 = ({4'b0, accum_cur} << 3) + ({4'b0, accum_cur} << 1)
                       + (hrhs_pkg::VALUE_W+4)'(digit);
    assign prev_cr   = (blank_cur == hrhs_pkg::BLANK_CR) || (blank_cur == hrhs_pkg::BLANK_CRLFCR);

    always_comb
    begin
        body_phase_next = body_cur;
        stopped_next    = stopped_cur;
        pos_next        = pos_cur;
        blank_next      = blank_cur;
        parse_next      = parse_cur;
        accum_next      = accum_cur;
        length_next     = length_cur;
        count_next      = count_cur;
        saw_nf_next     = saw_nf_cur;
        body_valid      = 1'b0;
        header_done     = 1'b0;
        continue_seen   = 1'b0;

        if (body_cur)
        begin
            body_valid = 1'b1;
            if (!(&count_cur))
            begin
                count_next = count_cur + COUNT_WIDTH'(1);
            end
        end
        else if (!stopped_cur)
        begin
            if (match.cont_hit)
            begin
                continue_seen = 1'b1;
                stopped_next  = 1'b1;
            end
            else if (match.nf_hit)
            begin
                saw_nf_next  = 1'b1;
                length_next  = '0;
                stopped_next = 1'b1;
            end
            else
            begin
                pos_next.cont_pos = match.cont_pos;
                pos_next.nf_pos   = match.nf_pos;
                if (match.len_hit)
                begin
                    pos_next.len_pos = '0;
                    parse_next       = hrhs_pkg::PARSE_SKIP;
                    accum_next       = '0;
                end
                else
                begin
                    pos_next.len_pos = match.len_pos;
                    if (parse_cur != hrhs_pkg::PARSE_IDLE && prev_cr && c == hrhs_pkg::CHAR_LF)
                    begin
                        // value commits on the line end
                        length_next = accum_cur;
                        parse_next  = hrhs_pkg::PARSE_IDLE;
                        accum_next  = '0;
                    end
                    else
                    begin
                        case (parse_cur)
                            hrhs_pkg::PARSE_IDLE:
                            begin
                            end
                            hrhs_pkg::PARSE_SKIP:
                            begin
                                parse_next = hrhs_pkg::PARSE_BLANK;
                            end
                            hrhs_pkg::PARSE_BLANK:
                            begin
                                if (c inside {[hrhs_pkg::CHAR_TAB:hrhs_pkg::CHAR_CR],
                                              hrhs_pkg::CHAR_SPACE})
                                begin
                                end
                                else if (c == hrhs_pkg::CHAR_PLUS)
                                begin
                                    parse_next = hrhs_pkg::PARSE_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    accum_next = hrhs_pkg::VALUE_W'(digit);
                                    parse_next = hrhs_pkg::PARSE_DIGITS;
                                end
                                else
                                begin
                                    accum_next = '0;
                                    parse_next = hrhs_pkg::PARSE_IGNORE;
                                end
                            end
                            hrhs_pkg::PARSE_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    if (accum_x10 > {4'b0, hrhs_pkg::VALUE_MAX})
                                    begin
                                        accum_next = hrhs_pkg::VALUE_MAX;
                                    end
                                    else
                                    begin
                                        accum_next = accum_x10[hrhs_pkg::VALUE_W-1:0];
                                    end
                                end
                                else
                                begin
                                    parse_next = hrhs_pkg::PARSE_IGNORE;
                                end
                            end
                            hrhs_pkg::PARSE_IGNORE:
                            begin
                            end
                            default:
                            begin
                                parse_next = hrhs_pkg::PARSE_IDLE;
                                accum_next = '0;
                            end
                        endcase
                    end
                end

                if (c == hrhs_pkg::CHAR_CR)
                begin
                    blank_next = (blank_cur == hrhs_pkg::BLANK_CRLF) ? hrhs_pkg::BLANK_CRLFCR
                                                                     : hrhs_pkg::BLANK_CR;
                end
                else if (c == hrhs_pkg::CHAR_LF)
                begin
                    if (blank_cur == hrhs_pkg::BLANK_CRLFCR)
                    begin
                        header_done     = 1'b1;
                        body_phase_next = 1'b1;
                        blank_next      = hrhs_pkg::BLANK_NONE;
                    end
                    else
                    begin
                        blank_next = (blank_cur == hrhs_pkg::BLANK_CR) ? hrhs_pkg::BLANK_CRLF
                                                                       : hrhs_pkg::BLANK_NONE;
                    end
                end
                else
                begin
                    blank_next = hrhs_pkg::BLANK_NONE;
                end
            end
        end

        // buffer end restarts the scan
        if (last_of_buffer)
        begin
            if (!body_phase_next)
            begin
                count_next = '0;
            end
            stopped_next = 1'b0;
            pos_next     = '0;
            blank_next   = hrhs_pkg::BLANK_NONE;
            parse_next   = hrhs_pkg::PARSE_IDLE;
            accum_next   = '0;
        end
    end

    assign count_ext = hrhs_pkg::COUNT_EXT_W'(count_next);

    always_comb
    begin
        result.body_valid     = body_valid;
        result.body_byte      = body_valid ? data_byte : 8'h00;
        result.header_done    = header_done;
        result.not_found_seen = saw_nf_next;
        result.continue_seen  = continue_seen;
        result.content_length = length_next;
        result.body_count     = count_ext[31:0];
        result.length_ok      = (length_next != '0)
                                && (count_ext == hrhs_pkg::COUNT_EXT_W'(length_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_phase_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            pos_reg        <= '0;
            blank_reg      <= hrhs_pkg::BLANK_NONE;
            parse_reg      <= hrhs_pkg::PARSE_IDLE;
            accum_reg      <= '0;
            length_reg     <= '0;
            count_reg      <= '0;
            saw_nf_reg     <= 1'b0;
        end
        else if (step)
        begin
            body_phase_reg <= body_phase_next;
            stopped_reg    <= stopped_next;
            pos_reg        <= pos_next;
            blank_reg      <= blank_next;
            parse_reg      <= parse_next;
            accum_reg      <= accum_next;
            length_reg     <= length_next;
            count_reg      <= count_next;
            saw_nf_reg     <= saw_nf_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/http_response_header_scanner_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_response_header_scanner_core_test
// Self-checking bench for the response header scanner. A short scripted
// response set covers the status matches, value syntax and buffer splits.
// Random responses with mixed case, random splits and noise bytes follow.
// Every result is checked against a cycle-free model of the scanner or a
// hand-written result, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------

module http_response_header_scanner_core_test;

    localparam int          CLK_PERIOD      = 10;
    localparam int          TOTAL_REQUESTS  = 600;
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned VALUE_CEILING   = 32'h7fff_ffff;

    localparam logic [7:0] CR = 8'h0d;
    localparam logic [7:0] LF = 8'h0a;

    // lower-case patterns that the scanner watches for
    localparam string CONTINUE_TEXT = "100 continue";
    localparam string NOTFOUND_TEXT = "/1.1 404 ";
    localparam string LENGTH_TEXT   = "content-length:";

    // one byte request with its flags; typed rows carry a hand-written result
    typedef struct {
        logic [7:0]        data;
        bit                last;
        bit                fresh;
        bit                typed;
        hrhs_pkg::result_t want;
    } byte_request_t;

    // scripted row: text is sent byte by byte, or raw alone when text is empty
    // (\015\012 is CR LF)
    typedef struct {
        string             text;
        logic [7:0]        raw;
        bit                fresh;
        bit                last;
        bit                typed;
        hrhs_pkg::result_t want;
    } script_row_t;

    localparam int N_ROWS = 22;

    script_row_t script [N_ROWS] = '{
        // zero byte right after reset, new transfer and buffer end together
        '{"", 8'h00, 1'b1, 1'b1, 1'b1, '0},
        '{"", 8'hff, 1'b0, 1'b1, 1'b1, '0},
        '{"HTTP/1.1 200 OK\015\012", 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{"CONTENT-length: 2\015\012", 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{"X-Pad: 1\015\012\015\012", 8'h00, 1'b0, 1'b0, 1'b0, '0},
        // two body bytes against a length of two
        '{"", 8'h00, 1'b0, 1'b0, 1'b1,
          '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 31'd2, 32'd1, 1'b0}},
        '{"", 8'hff, 1'b0, 1'b1, 1'b1,
          '{1'b1, 8'hff, 1'b0, 1'b0, 1'b0, 31'd2, 32'd2, 1'b1}},
        // continue stops the scan, blank line after it is ignored
        '{"HTTP/1.1 100 Continue", 8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{"\015\012\015\012", 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // value saturation, then a 404 clears the length
        '{"hTTp/1.1 200 OK\015\012Content-Length: 99999999999\015\012",
          8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{"HTTP/1.1 404 ", 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{"Not Found\015\012\015\012", 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // matcher fallback on repeated prefixes
        '{"HTTP/1./1.1 404 \015\012", 8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{"x 1100 Continue", 8'h00, 1'b1, 1'b1, 1'b0, '0},
        // blanks, plus sign, trailing junk, minus sign, empty value
        '{"Content-Length:\t\t+17 trailing\015\012", 8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{"Content-Length: 8\015\012Content-Length: -5\015\012",
          8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{"Content-Length: 9\015\012Content-Length:\015\012",
          8'h00, 1'b0, 1'b0, 1'b0, '0},
        // buffer ends break a match and an open value
        '{"Content-Len", 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{"gth: 3\015\012content-length: 4", 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // a second match restarts the value, then header end and body
        '{"Content-Length: 12 Content-Length: 5\015\012", 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{"\015\012abc", 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // new transfer while in body phase brings everything back to zero
        '{"", 8'h41, 1'b1, 1'b1, 1'b1, '0}
    };

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic [7:0] data_byte      = 8'h00;
    logic       last_of_buffer = 1'b0;
    logic       new_transfer   = 1'b0;
    logic       out_stall      = 1'b0;

    logic                         in_stall;
    logic                         out_valid;
    logic                         body_valid;
    logic [7:0]                   body_byte;
    logic                         header_done;
    logic                         not_found_seen;
    logic                         continue_seen;
    logic [hrhs_pkg::VALUE_W-1:0] content_length;
    logic [31:0]                  body_count;
    logic                         length_ok;

    byte_request_t     byte_requests[$];
    hrhs_pkg::result_t pending_results[$];
    bit                mismatch_seen = 1'b0;
    int unsigned       cycle_count   = 0;
    bit                in_calm       = 1'b0;
    bit                out_calm      = 1'b0;
    int unsigned       stall_left    = 0;

    // ------------------------------------------------------------------------
    // scanner model state, mirrors the block after reset
    // ------------------------------------------------------------------------
    bit                      in_body     = 1'b0;
    bit                      stopped     = 1'b0;
    int unsigned             cont_pos    = 0;
    int unsigned             nf_pos      = 0;
    int unsigned             len_pos     = 0;
    hrhs_pkg::blank_pos_t    crlf_pos    = hrhs_pkg::BLANK_NONE;
    hrhs_pkg::parse_state_t  parse_st    = hrhs_pkg::PARSE_IDLE;
    int unsigned             accum       = 0;
    logic [30:0]             length_val  = '0;
    logic [31:0]             body_cnt    = '0;
    bit                      saw_404     = 1'b0;

    http_response_header_scanner_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_of_buffer (last_of_buffer),
        .new_transfer   (new_transfer),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .body_valid     (body_valid),
        .body_byte      (body_byte),
        .header_done    (header_done),
        .not_found_seen (not_found_seen),
        .continue_seen  (continue_seen),
        .content_length (content_length),
        .body_count     (body_count),
        .length_ok      (length_ok)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // matched length after byte c, falling back to the longest border on a miss
    function automatic int unsigned next_match(input string pat, input int unsigned matched,
                                               input logic [7:0] c);
        int  p;
        int  k;
        int  j;
        bit  ok;
        p = (matched >= pat.len()) ? 0 : matched;
        if (pat[p] == c)
        begin
            return p + 1;
        end
        for (k = p; k >= 1; k--)
        begin
            ok = (pat[k-1] == c);
            for (j = 0; ok && j + 1 < k; j++)
            begin
                if (pat[j] != pat[p - k + 1 + j])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    function automatic void clear_scan();
        stopped  = 1'b0;
        cont_pos = 0;
        nf_pos   = 0;
        len_pos  = 0;
        crlf_pos = hrhs_pkg::BLANK_NONE;
        parse_st = hrhs_pkg::PARSE_IDLE;
        accum    = 0;
    endfunction

    // one byte through the content-length value parser
    function automatic void parse_value_char(input logic [7:0] c);
        bit          digit;
        int unsigned d;
        digit = (c >= "0" && c <= "9");
        d     = 32'(c - "0");
        case (parse_st)
            hrhs_pkg::PARSE_IDLE:
            begin
            end
            hrhs_pkg::PARSE_SKIP:
            begin
                parse_st = hrhs_pkg::PARSE_BLANK;
            end
            hrhs_pkg::PARSE_BLANK:
            begin
                if ((c >= 8'd9 && c <= 8'd13) || c == " ")
                begin
                end
                else if (c == "+")
                begin
                    parse_st = hrhs_pkg::PARSE_DIGITS;
                end
                else if (digit)
                begin
                    accum    = d;
                    parse_st = hrhs_pkg::PARSE_DIGITS;
                end
                else
                begin
                    accum    = 0;
                    parse_st = hrhs_pkg::PARSE_IGNORE;
                end
            end
            hrhs_pkg::PARSE_DIGITS:
            begin
                if (digit)
                begin
                    if (accum > (VALUE_CEILING - d) / 10)
                    begin
                        accum = VALUE_CEILING;
                    end
                    else
                    begin
                        accum = accum * 10 + d;
                    end
                end
                else
                begin
                    parse_st = hrhs_pkg::PARSE_IGNORE;
                end
            end
            hrhs_pkg::PARSE_IGNORE:
            begin
            end
            default:
            begin
                parse_st = hrhs_pkg::PARSE_IDLE;
                accum    = 0;
            end
        endcase
    endfunction

    // expected result of one accepted byte request, advancing the model state
    function automatic hrhs_pkg::result_t scan_predict(input logic [7:0] b, input bit last,
                                                       input bit fresh);
        hrhs_pkg::result_t r;
        logic [7:0]        c;
        int unsigned       nc;
        int unsigned       nn;
        int unsigned       nl;
        bit                prev_cr;
        r = '0;
        if (fresh)
        begin
            in_body    = 1'b0;
            length_val = '0;
            body_cnt   = '0;
            saw_404    = 1'b0;
            clear_scan();
        end
        if (in_body)
        begin
            r.body_valid = 1'b1;
            r.body_byte  = b;
            if (body_cnt != '1)
            begin
                body_cnt++;
            end
        end
        else if (!stopped)
        begin
            c  = fold_case(b);
            nc = next_match(CONTINUE_TEXT, cont_pos, c);
            nn = next_match(NOTFOUND_TEXT, nf_pos, c);
            nl = next_match(LENGTH_TEXT, len_pos, c);
            if (nc == hrhs_pkg::PAT_CONTINUE_LEN)
            begin
                r.continue_seen = 1'b1;
                stopped         = 1'b1;
            end
            else if (nn == hrhs_pkg::PAT_NOTFOUND_LEN)
            begin
                saw_404    = 1'b1;
                length_val = '0;
                stopped    = 1'b1;
            end
            else
            begin
                prev_cr  = (crlf_pos == hrhs_pkg::BLANK_CR
                            || crlf_pos == hrhs_pkg::BLANK_CRLFCR);
                cont_pos = nc;
                nf_pos   = nn;
                if (nl == hrhs_pkg::PAT_LENGTH_LEN)
                begin
                    len_pos  = 0;
                    parse_st = hrhs_pkg::PARSE_SKIP;
                    accum    = 0;
                end
                else
                begin
                    len_pos = nl;
                    if (parse_st != hrhs_pkg::PARSE_IDLE && prev_cr && c == LF)
                    begin
                        length_val = accum[30:0];
                        parse_st   = hrhs_pkg::PARSE_IDLE;
                        accum      = 0;
                    end
                    else
                    begin
                        parse_value_char(c);
                    end
                end
                if (c == CR)
                begin
                    crlf_pos = (crlf_pos == hrhs_pkg::BLANK_CRLF) ? hrhs_pkg::BLANK_CRLFCR
                                                                  : hrhs_pkg::BLANK_CR;
                end
                else if (c == LF)
                begin
                    if (crlf_pos == hrhs_pkg::BLANK_CRLFCR)
                    begin
                        r.header_done = 1'b1;
                        in_body       = 1'b1;
                        crlf_pos      = hrhs_pkg::BLANK_NONE;
                    end
                    else
                    begin
                        crlf_pos = (crlf_pos == hrhs_pkg::BLANK_CR) ? hrhs_pkg::BLANK_CRLF
                                                                    : hrhs_pkg::BLANK_NONE;
                    end
                end
                else
                begin
                    crlf_pos = hrhs_pkg::BLANK_NONE;
                end
            end
        end
        if (last)
        begin
            if (!in_body)
            begin
                body_cnt = '0;
            end
            clear_scan();
        end
        r.not_found_seen = saw_404;
        r.content_length = length_val;
        r.body_count     = body_cnt;
        r.length_ok      = (length_val != 0) && (body_cnt == 32'(length_val));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic void queue_request(input logic [7:0] b, input bit last, input bit fresh,
                                          input bit typed, input hrhs_pkg::result_t want);
        byte_request_t req;
        req.data  = b;
        req.last  = last;
        req.fresh = fresh;
        req.typed = typed;
        req.want  = want;
        byte_requests.push_back(req);
    endfunction

    // text as byte requests: fresh on the first, last on the final one,
    // optional random buffer splits and random letter case
    function automatic void add_text(input string s, input bit fresh, input bit last,
                                     input int unsigned split_odds, input bit mix_case);
        logic [7:0] ch;
        bit         split;
        for (int i = 0; i < s.len(); i++)
        begin
            ch    = s[i];
            split = (split_odds != 0) && ($urandom_range(0, split_odds - 1) == 0);
            if (mix_case && $urandom_range(0, 1) == 1)
            begin
                if (ch >= "a" && ch <= "z")
                begin
                    ch = ch - 8'd32;
                end
                else if (ch >= "A" && ch <= "Z")
                begin
                    ch = ch + 8'd32;
                end
            end
            queue_request(ch, split || (last && i == s.len() - 1), fresh && i == 0,
                          1'b0, '0);
        end
    endfunction

    // one header line: a content-length in one of its syntax variants or filler
    function automatic string random_header();
        string value;
        string lead;
        string tail;
        string filler;
        if ($urandom_range(0, 9) < 6)
        begin
            case ($urandom_range(0, 6))
                0: value = $sformatf("%0d", $urandom);
                1: value = "99999999999";
                2: value = $sformatf("-%0d", $urandom_range(0, 20));
                3: value = $sformatf("+%0d", $urandom_range(0, 20));
                4: value = "";
                default: value = $sformatf("%0d", $urandom_range(0, 14));
            endcase
            case ($urandom_range(0, 3))
                0: lead = "";
                1: lead = "\t";
                2: lead = " \t ";
                default: lead = " ";
            endcase
            tail = ($urandom_range(0, 3) == 0) ? " ;q" : "";
            return $sformatf("Content-Length:%s%s%s\015\012", lead, value, tail);
        end
        filler = "";
        repeat ($urandom_range(0, 10))
        begin
            filler = $sformatf("%s%c", filler, 8'($urandom_range(32, 126)));
        end
        return $sformatf("X-Tag: %s\015\012", filler);
    endfunction

    // response, mostly well-formed, with random content and random buffer splits
    function automatic void queue_random_response();
        string head;
        bit    fresh;
        int    n_body;
        fresh = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) == 0)
        begin
            add_text("HTTP/1.1 100 Continue\015\012\015\012", fresh, 1'b1, 0, 1'b1);
            fresh = 1'b0;
        end
        head = ($urandom_range(0, 5) == 0) ? "HTTP/1.1 404 Not Found\015\012"
                                           : "HTTP/1.1 200 OK\015\012";
        repeat ($urandom_range(0, 3))
        begin
            head = {head, random_header()};
        end
        if ($urandom_range(0, 9) != 0)
        begin
            head = {head, "\015\012"};
        end
        add_text(head, fresh, 1'b0, 40, 1'b1);
        n_body = $urandom_range(0, 14);
        for (int i = 0; i < n_body; i++)
        begin
            queue_request(8'($urandom_range(0, 255)),
                          (i == n_body - 1) && ($urandom_range(0, 1) == 1), 1'b0, 1'b0, '0);
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        if (calm)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall, compare each taken result with the oldest
    // pending expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        hrhs_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending, body_byte %0h", body_byte);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("body_valid", 32'(want.body_valid), 32'(body_valid));
                    check_field("body_byte", 32'(want.body_byte), 32'(body_byte));
                    check_field("header_done", 32'(want.header_done), 32'(header_done));
                    check_field("not_found_seen", 32'(want.not_found_seen),
                                32'(not_found_seen));
                    check_field("continue_seen", 32'(want.continue_seen),
                                32'(continue_seen));
                    check_field("content_length", 32'(want.content_length),
                                32'(content_length));
                    check_field("body_count", want.body_count, body_count);
                    check_field("length_ok", 32'(want.length_ok), 32'(length_ok));
                end
            end
            // stall pattern: random holds, with calm stretches of none
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap(out_calm);
                end
            end
            if ($urandom_range(0, 59) == 0)
            begin
                out_calm = !out_calm;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side: script, then random responses and noise
    // ------------------------------------------------------------------------
    initial
    begin
        byte_request_t     req;
        hrhs_pkg::result_t predicted;
        int unsigned       gap;

        foreach (script[r])
        begin
            if (script[r].text.len() == 0)
            begin
                queue_request(script[r].raw, script[r].last, script[r].fresh,
                              script[r].typed, script[r].want);
            end
            else
            begin
                add_text(script[r].text, script[r].fresh, script[r].last, 0, 1'b0);
            end
        end

        while (byte_requests.size() < TOTAL_REQUESTS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // noise burst: any byte, random buffer ends and transfer starts
                repeat ($urandom_range(1, 20))
                begin
                    queue_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 15) == 0, 1'b0, '0);
                end
            end
            else
            begin
                queue_random_response();
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (byte_requests.size() != 0)
        begin
            req = byte_requests.pop_front();
            gap = pick_gap(in_calm);
            if ($urandom_range(0, 59) == 0)
            begin
                in_calm = !in_calm;
            end
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid       <= 1'b1;
            data_byte      <= req.data;
            last_of_buffer <= req.last;
            new_transfer   <= req.fresh;
            // request taken at the edge where stall is low
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            predicted = scan_predict(req.data, req.last, req.fresh);
            pending_results.push_back(req.typed ? req.want : predicted);
        end
        in_valid <= 1'b0;

        // drain, then keep running to catch stray results
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (!mismatch_seen)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
